FILE: rtl/core/ts2cal_pkg.sv
// Shared types and constants for the timestamp to calendar date converter.
// Used by ts2cal_ctrl, ts2cal_datapath and timestamp_to_calendar_date.
// No dependencies.
package ts2cal_pkg;

   // Divisions performed by the shared reciprocal divider, in order of use
   typedef enum logic [1:0] {
      DIV_SEC   = 2'd0,
      DIV_MIN   = 2'd1,
      DIV_BLOCK = 2'd2,
      DIV_HOUR  = 2'd3
   } div_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        load_in;
      logic        mul;
      logic        qd;
      logic        fix;
      logic        year_step;
      logic        day_fix;
      logic        month_step;
      logic        month_last;
      logic        load_out;
      div_sel_type sel;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic year_fits;
      logic leap_day;
      logic month_more;
   } status_type;

   localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
   localparam logic [15:0] HOURS_PER_YEAR  = 16'd8760;
   localparam logic [15:0] HOURS_PER_DAY   = 16'd24;
   localparam logic [15:0] SECS_PER_MIN    = 16'd60;
   localparam logic [15:0] BLOCK_HOURS     = 16'd35064;   // 1461 days of 24 hours
   localparam logic [1:0]  MAX_EXTRA_YEARS = 2'd3;
   localparam logic [8:0]  LEAP_DAY_OF_YEAR = 9'd60;
   localparam logic [4:0]  LEAP_DAY_OF_FEB = 5'd29;
   localparam logic [3:0]  MONTH_FEB       = 4'd2;
   localparam logic [3:0]  LAST_MONTH_IDX  = 4'd11;

   // Reciprocals floor(2^32 / d): the estimate is exact or one short
   localparam logic [31:0] RECIP_MIN   = 32'((64'd1 << 32) / 64'd60);
   localparam logic [31:0] RECIP_BLOCK = 32'((64'd1 << 32) / 64'd35064);
   localparam logic [31:0] RECIP_HOUR  = 32'((64'd1 << 32) / 64'd24);

   function automatic logic [15:0] divisor(input div_sel_type sel);
      logic [15:0] d;
      unique case (sel)
         DIV_SEC, DIV_MIN: d = SECS_PER_MIN;
         DIV_BLOCK:        d = BLOCK_HOURS;
         DIV_HOUR:         d = HOURS_PER_DAY;
         default:          d = SECS_PER_MIN;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] recip(input div_sel_type sel);
      logic [31:0] m;
      unique case (sel)
         DIV_SEC, DIV_MIN: m = RECIP_MIN;
         DIV_BLOCK:        m = RECIP_BLOCK;
         DIV_HOUR:         m = RECIP_HOUR;
         default:          m = RECIP_MIN;
      endcase
      return m;
   endfunction

   // Month lengths of a common year, index 0 is January
   function automatic logic [4:0] month_len(input logic [3:0] idx);
      logic [4:0] len;
      unique case (idx)
         4'd1:                   len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/core/timestamp_to_calendar_date.sv
// Per word: seconds, minutes and four-year blocks are divided on the shared
// reciprocal divider (MUL, QD and FIX states for each), then zero to three year
// steps, the hour division, the day fix and the month walk (up to 12, none on a
// leap day). One word at a time: a new word is taken only in the idle state; a
// finished word waits in the result register while the next one is taken.
// Reset (synchronous, active high) clears the controller and the result valid only.
module timestamp_to_calendar_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_timestamp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second_of_minute
);

   ts2cal_pkg::cmd_type    cmd;
   ts2cal_pkg::status_type status;

   // Sequencer
   ts2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and result registers
   ts2cal_datapath u_datapath (
      .clock         (clock),
      .req_timestamp (req_timestamp),
      .cmd           (cmd),
      .status        (status),
      .out_year      (rsp_year),
      .out_month     (rsp_month),
      .out_day       (rsp_day),
      .out_hour      (rsp_hour),
      .out_minute    (rsp_minute),
      .out_second    (rsp_second_of_minute)
   );

endmodule

FILE: rtl/core/ts2cal_datapath.sv
// Datapath of the calendar converter: reciprocal divider, year stepper,
// month walker and result registers. Depends on ts2cal_pkg.
module ts2cal_datapath (
   input  logic                   clock,
   input  logic [31:0]            req_timestamp,
   input  ts2cal_pkg::cmd_type    cmd,
   output ts2cal_pkg::status_type status,
   output logic [11:0]            out_year,
   output logic [3:0]             out_month,
   output logic [4:0]             out_day,
   output logic [4:0]             out_hour,
   output logic [5:0]             out_minute,
   output logic [5:0]             out_second
);

   logic [31:0] num_ff,  num_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] quo_ff,  quo_in;
   logic [31:0] qd_ff,   qd_in;
   logic [5:0]  sec_ff,  sec_in;
   logic [5:0]  min_ff,  min_in;
   logic [4:0]  hr_ff,   hr_in;
   logic [11:0] year_ff, year_in;
   logic [8:0]  doy_ff,  doy_in;
   logic [3:0]  mon_ff,  mon_in;

   logic [11:0] oyear_ff, oyear_in;
   logic [3:0]  omon_ff,  omon_in;
   logic [4:0]  oday_ff,  oday_in;
   logic [4:0]  ohr_ff,   ohr_in;
   logic [5:0]  omin_ff,  omin_in;
   logic [5:0]  osec_ff,  osec_in;

   logic [15:0] div_d;
   logic [47:0] qd_full;
   logic [31:0] rem;
   logic        rem_over;
   logic [31:0] q_fix;
   logic [31:0] r_fix;
   logic        leap;
   logic [15:0] year_hours;
   logic [4:0]  cur_len;

   // Divider helpers: quotient estimate times divisor, then one correction
   assign div_d    = ts2cal_pkg::divisor(cmd.sel);
   assign qd_full  = {16'd0, prod_ff[63:32]} * {32'd0, div_d};
   assign rem      = num_ff - qd_ff;
   assign rem_over = rem >= {16'd0, div_d};
   assign q_fix    = rem_over ? quo_ff + 32'd1 : quo_ff;
   assign r_fix    = rem_over ? rem - {16'd0, div_d} : rem;

   // Year and month helpers
   assign leap       = year_ff[1:0] == 2'd0;
   assign year_hours = leap ? ts2cal_pkg::HOURS_PER_YEAR + ts2cal_pkg::HOURS_PER_DAY
                            : ts2cal_pkg::HOURS_PER_YEAR;
   assign cur_len    = ts2cal_pkg::month_len(mon_ff);

   assign status.year_fits  = num_ff < {16'd0, year_hours};
   assign status.leap_day   = leap && (doy_ff == ts2cal_pkg::LEAP_DAY_OF_YEAR);
   assign status.month_more = (mon_ff < ts2cal_pkg::LAST_MONTH_IDX)
                              && ({4'd0, cur_len} < doy_ff);

   // Next values of the working registers
   always_comb begin
      num_in  = num_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      qd_in   = qd_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hr_in   = hr_ff;
      year_in = year_ff;
      doy_in  = doy_ff;
      mon_in  = mon_ff;
      if (cmd.load_in) begin
         num_in = req_timestamp;
      end
      if (cmd.mul) begin
         prod_in = {32'd0, num_ff} * {32'd0, ts2cal_pkg::recip(cmd.sel)};
      end
      if (cmd.qd) begin
         quo_in = prod_ff[63:32];
         qd_in  = qd_full[31:0];
      end
      if (cmd.fix) begin
         unique case (cmd.sel)
            ts2cal_pkg::DIV_SEC: begin
               sec_in = r_fix[5:0];
               num_in = q_fix;
            end
            ts2cal_pkg::DIV_MIN: begin
               min_in = r_fix[5:0];
               num_in = q_fix;
            end
            ts2cal_pkg::DIV_BLOCK: begin
               year_in = ts2cal_pkg::EPOCH_YEAR + {q_fix[9:0], 2'b00};
               num_in  = r_fix;
            end
            ts2cal_pkg::DIV_HOUR: begin
               hr_in  = r_fix[4:0];
               doy_in = q_fix[8:0] + 9'd1;
            end
            default: begin
               num_in = num_ff;
            end
         endcase
      end
      if (cmd.year_step) begin
         num_in  = num_ff - {16'd0, year_hours};
         year_in = year_ff + 12'd1;
      end
      // Leap day is caught before the walk; later days shift back by one
      if (cmd.day_fix) begin
         if (status.leap_day) begin
            mon_in = ts2cal_pkg::MONTH_FEB;
         end else begin
            mon_in = 4'd0;
            if (leap && (doy_ff > ts2cal_pkg::LEAP_DAY_OF_YEAR)) begin
               doy_in = doy_ff - 9'd1;
            end
         end
      end
      if (cmd.month_step) begin
         doy_in = doy_ff - {4'd0, cur_len};
         mon_in = mon_ff + 4'd1;
      end
      if (cmd.month_last) begin
         mon_in = mon_ff + 4'd1;
      end
   end

   // Result registers, loaded once the output word is free
   always_comb begin
      oyear_in = oyear_ff;
      omon_in  = omon_ff;
      oday_in  = oday_ff;
      ohr_in   = ohr_ff;
      omin_in  = omin_ff;
      osec_in  = osec_ff;
      if (cmd.load_out) begin
         oyear_in = year_ff;
         omon_in  = mon_ff;
         oday_in  = ((mon_ff == ts2cal_pkg::MONTH_FEB)
                     && (doy_ff == ts2cal_pkg::LEAP_DAY_OF_YEAR))
                    ? ts2cal_pkg::LEAP_DAY_OF_FEB : doy_ff[4:0];
         ohr_in   = hr_ff;
         omin_in  = min_ff;
         osec_in  = sec_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      qd_ff    <= qd_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hr_ff    <= hr_in;
      year_ff  <= year_in;
      doy_ff   <= doy_in;
      mon_ff   <= mon_in;
      oyear_ff <= oyear_in;
      omon_ff  <= omon_in;
      oday_ff  <= oday_in;
      ohr_ff   <= ohr_in;
      omin_ff  <= omin_in;
      osec_ff  <= osec_in;
   end

   assign out_year   = oyear_ff;
   assign out_month  = omon_ff;
   assign out_day    = oday_ff;
   assign out_hour   = ohr_ff;
   assign out_minute = omin_ff;
   assign out_second = osec_ff;

endmodule

FILE: rtl/core/ts2cal_ctrl.sv
// Controller of the calendar converter: sequences the divisions, year steps
// and month walk, and owns both handshakes. Depends on ts2cal_pkg.
module ts2cal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ts2cal_pkg::status_type status,
   output ts2cal_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_QD     = 8'b0000_0100,
      ST_FIX    = 8'b0000_1000,
      ST_YEAR   = 8'b0001_0000,
      ST_DAYFIX = 8'b0010_0000,
      ST_MONTH  = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   ts2cal_pkg::div_sel_type sel_ff,   sel_in;
   logic [1:0]              cnt_ff,   cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.sel      = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               sel_in      = ts2cal_pkg::DIV_SEC;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_QD;
         end
         ST_QD: begin
            cmd.qd   = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            unique case (sel_ff)
               ts2cal_pkg::DIV_SEC: begin
                  sel_in   = ts2cal_pkg::DIV_MIN;
                  state_in = ST_MUL;
               end
               ts2cal_pkg::DIV_MIN: begin
                  sel_in   = ts2cal_pkg::DIV_BLOCK;
                  state_in = ST_MUL;
               end
               ts2cal_pkg::DIV_BLOCK: begin
                  sel_in   = ts2cal_pkg::DIV_HOUR;
                  cnt_in   = 2'd0;
                  state_in = ST_YEAR;
               end
               ts2cal_pkg::DIV_HOUR: begin
                  state_in = ST_DAYFIX;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         // Up to three single-year steps past the four-year block
         ST_YEAR: begin
            if (status.year_fits) begin
               state_in = ST_MUL;
            end else begin
               cmd.year_step = 1'b1;
               cnt_in        = cnt_ff + 2'd1;
               if (cnt_ff == ts2cal_pkg::MAX_EXTRA_YEARS - 2'd1) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DAYFIX: begin
            cmd.day_fix = 1'b1;
            state_in    = status.leap_day ? ST_OUT : ST_MONTH;
         end
         ST_MONTH: begin
            if (status.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               cmd.month_last = 1'b1;
               state_in       = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= ts2cal_pkg::DIV_SEC;
         cnt_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_year_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_YEAR |-> cnt_ff < ts2cal_pkg::MAX_EXTRA_YEARS)
      else $error("year stepper ran past three years");

   a_year_sel: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_YEAR |-> sel_ff == ts2cal_pkg::DIV_HOUR)
      else $error("divider not set up for hours during year steps");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result word raised outside the output state");

endmodule

FILE: dv/timestamp_to_calendar_date_tb.sv
// Self-checking bench for timestamp_to_calendar_date: a queue-fed driver, a
// checking monitor and a behavioural calendar predictor built into this module.
// Depends only on the RTL top level; no files, no arguments.
module timestamp_to_calendar_date_tb;

   // Expected calendar word at the result port widths
   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second_of_minute;
   } calendar_word_type;

   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned RANDOM_WORDS  = 1850;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned SECS_PER_DAY  = 86400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second_of_minute;

   logic [31:0]       stamps_to_send[$];
   calendar_word_type dates_due[$];
   int unsigned       words_total = 0;
   int unsigned       words_taken = 0;
   int unsigned       fault_count = 0;
   int unsigned       gap_left = 0;
   int unsigned       feed_calm = 0;
   int unsigned       stall_left = 0;
   int unsigned       sink_calm = 0;

   timestamp_to_calendar_date dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_timestamp        (req_timestamp),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_year             (rsp_year),
      .rsp_month            (rsp_month),
      .rsp_day              (rsp_day),
      .rsp_hour             (rsp_hour),
      .rsp_minute           (rsp_minute),
      .rsp_second_of_minute (rsp_second_of_minute)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Common-year month lengths, January first
   function automatic int unsigned days_in_month(int unsigned idx);
      case (idx)
         1:             return 28;
         3, 5, 8, 10:   return 30;
         default:       return 31;
      endcase
   endfunction

   // Calendar fields of a timestamp, every fourth year taken as leap
   function automatic calendar_word_type calendar_of(logic [31:0] stamp);
      calendar_word_type w;
      int unsigned       t, yr, yday, mon, span;
      bit                leap;
      t = stamp;
      w.second_of_minute = 6'(t % 60);
      t = t / 60;
      w.minute = 6'(t % 60);
      t = t / 60;
      yr = (t / (1461 * 24)) * 4 + 1970;
      t = t % (1461 * 24);
      // at most three further years inside a four-year block
      for (int unsigned k = 0; k < 3; k++) begin
         span = ((yr & 3) == 0) ? 8784 : 8760;
         if (t < span) break;
         t = t - span;
         yr++;
      end
      w.hour = 5'(t % 24);
      yday = t / 24 + 1;
      leap = (yr & 3) == 0;
      if (leap && yday == 60) begin
         mon = 2;
         yday = 29;
      end else begin
         if (leap && yday > 60) yday--;
         mon = 0;
         while (mon < 11 && days_in_month(mon) < yday) begin
            yday = yday - days_in_month(mon);
            mon++;
         end
         mon++;
      end
      w.year  = 12'(yr);
      w.month = 4'(mon);
      w.day   = 5'(yday);
      return w;
   endfunction

   // Timestamp of a given year, day of year and second of day (same leap rule)
   function automatic logic [31:0] stamp_of(int unsigned yr, int unsigned yday,
                                            int unsigned sod);
      longint unsigned days;
      days = 0;
      for (int unsigned y = 1970; y < yr; y++) days += ((y & 3) == 0) ? 366 : 365;
      days += yday - 1;
      return 32'(days * SECS_PER_DAY + sod);
   endfunction

   // Idle length: mostly nothing or a few cycles, now and then a long one
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // Random word, half uniform and half clustered round hour, day, month and year edges
   function automatic logic [31:0] random_stamp();
      int unsigned yr, yday, sod;
      if ($urandom_range(1) == 0) return $urandom;
      yr = ($urandom_range(3) == 0) ? $urandom_range(2105, 2096) : $urandom_range(2105, 1970);
      case ($urandom_range(4))
         0:       yday = $urandom_range(3, 1);
         1:       yday = $urandom_range(32, 28);
         2:       yday = $urandom_range(63, 57);
         3:       yday = $urandom_range(366, 363);
         default: yday = $urandom_range(366, 1);
      endcase
      case ($urandom_range(3))
         0:       sod = $urandom_range(2);
         1:       sod = $urandom_range(SECS_PER_DAY - 1, SECS_PER_DAY - 3);
         2:       sod = $urandom_range(3601, 3598);
         default: sod = $urandom_range(SECS_PER_DAY - 1);
      endcase
      return stamp_of(yr, yday, sod);
   endfunction

   // Driver: presents queued words, random gaps after each accepted word
   always @(posedge clock) begin : feed_proc
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            dates_due.push_back(calendar_of(req_timestamp));
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (stamps_to_send.size() != 0) begin
               req_valid     <= 1'b1;
               req_timestamp <= stamps_to_send.pop_front();
               if (feed_calm != 0) begin
                  feed_calm--;
                  gap_left <= 0;
               end else begin
                  if ($urandom_range(59) == 0) feed_calm = $urandom_range(80, 20);
                  gap_left <= pause_len();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result word, then picks the next stall
   always @(posedge clock) begin : check_proc
      calendar_word_type want, got;
      int unsigned       n;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second_of_minute};
            if (dates_due.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result word %0d-%0d-%0d %0d:%0d:%0d",
                           got.year, got.month, got.day, got.hour, got.minute,
                           got.second_of_minute);
            end else begin
               want = dates_due.pop_front();
               if (got !== want) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display({"mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, ",
                               "got %0d-%0d-%0d %0d:%0d:%0d"},
                              want.year, want.month, want.day, want.hour, want.minute,
                              want.second_of_minute, got.year, got.month, got.day,
                              got.hour, got.minute, got.second_of_minute);
               end
            end
         end
         // back-pressure: random stalls with occasional calm stretches
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (sink_calm != 0) begin
            sink_calm--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(99) == 0) begin
            sink_calm = $urandom_range(120, 30);
            rsp_stall <= 1'b0;
         end else begin
            n = ($urandom_range(3) == 0) ? pause_len() : 0;
            rsp_stall  <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : 0;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      // directed: field extremes, minute/hour/day edges, leap day, year and block edges
      stamps_to_send.push_back(32'h0000_0000);
      stamps_to_send.push_back(32'hFFFF_FFFF);
      stamps_to_send.push_back(32'h8000_0000);
      stamps_to_send.push_back(32'h7FFF_FFFF);
      stamps_to_send.push_back(32'd59);
      stamps_to_send.push_back(32'd60);
      stamps_to_send.push_back(32'd3599);
      stamps_to_send.push_back(32'd3600);
      stamps_to_send.push_back(32'd86399);
      stamps_to_send.push_back(32'd86400);
      stamps_to_send.push_back(stamp_of(1972, 59, SECS_PER_DAY - 1));
      stamps_to_send.push_back(stamp_of(1972, 60, 0));
      stamps_to_send.push_back(stamp_of(1972, 60, SECS_PER_DAY - 1));
      stamps_to_send.push_back(stamp_of(1972, 61, 0));
      stamps_to_send.push_back(stamp_of(1972, 366, SECS_PER_DAY - 1));
      stamps_to_send.push_back(stamp_of(1973, 1, 0));
      stamps_to_send.push_back(stamp_of(1973, 60, 0));
      stamps_to_send.push_back(stamp_of(1973, 365, SECS_PER_DAY - 1));
      stamps_to_send.push_back(stamp_of(1974, 1, 0));
      stamps_to_send.push_back(32'(1461 * SECS_PER_DAY - 1));
      stamps_to_send.push_back(32'(1461 * SECS_PER_DAY));
      stamps_to_send.push_back(stamp_of(2000, 60, 43200));
      stamps_to_send.push_back(stamp_of(2099, 365, SECS_PER_DAY - 1));
      stamps_to_send.push_back(stamp_of(2100, 60, 45296));
      stamps_to_send.push_back(stamp_of(2100, 61, 0));
      for (int unsigned i = 0; i < RANDOM_WORDS; i++) stamps_to_send.push_back(random_stamp());
      words_total = stamps_to_send.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (!(words_taken == words_total && dates_due.size() == 0)) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && dates_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(20 * 1000000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: timestamp_to_calendar_date.f
rtl/core/ts2cal_pkg.sv
rtl/core/ts2cal_datapath.sv
rtl/core/ts2cal_ctrl.sv
rtl/core/timestamp_to_calendar_date.sv
dv/timestamp_to_calendar_date_tb.sv
